@@ rtl/pixel_hit_occupancy_counter_defines.svh @@
// assertion macros for the pixel hit occupancy counter
`ifndef PIXEL_HIT_OCCUPANCY_COUNTER_DEFINES_SVH
`define PIXEL_HIT_OCCUPANCY_COUNTER_DEFINES_SVH
// assert that an antecedent implies a consequent in the next cycle
`define PHOC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
// assert that a condition holds in every cycle out of reset
`define PHOC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
`endif

@@ rtl/phoc_pkg.sv @@
// shared types and constants of the pixel hit occupancy counter
package phoc_pkg;
  localparam int unsigned MaxColumns = 128;
  localparam int unsigned MaxRows    = 128;
  localparam int unsigned ColW  = $clog2(MaxColumns);
  localparam int unsigned RowW  = $clog2(MaxRows);
  localparam int unsigned AddrW = ColW + RowW;
  localparam int unsigned Pixels = MaxColumns * MaxRows;
  localparam int unsigned SizeW = 11;   // holds up to 2047

  localparam logic [1:0] CmdHit  = 2'd0;
  localparam logic [1:0] CmdEoe  = 2'd1;
  localparam logic [1:0] CmdRead = 2'd2;

  localparam logic [1:0] RegPitch = 2'd0;
  localparam logic [1:0] RegCols  = 2'd1;
  localparam logic [1:0] RegRows  = 2'd2;
  localparam logic [1:0] RegThr   = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [23:0] hit_x;
    logic signed [23:0] hit_y;
    logic [31:0]        hit_energy;
    logic [6:0]         read_column;
    logic [6:0]         read_row;
  } in_word_t;

  typedef struct packed {
    logic        hit_accepted;
    logic [6:0]  hit_column;
    logic [6:0]  hit_row;
    logic [31:0] trigger_count;
    logic [31:0] events_seen;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_word_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [42:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [42:0] quotient;
  } div_rsp_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction
endpackage

@@ rtl/phoc_stream_if.sv @@
// valid/ready channel interfaces
interface phoc_in_if import phoc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface phoc_out_if import phoc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface phoc_cfg_if import phoc_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/phoc_ram.sv @@
// generic single port ram with registered read
module phoc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ rtl/phoc_divider.sv @@
// restoring divider, one quotient bit per cycle
module phoc_divider import phoc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  logic [42:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d, den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [17:0] trial;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q, quo_q[42]} - {1'b0, den_q};
    if (req_i.start) begin
      quo_d = req_i.dividend; rem_d = '0; den_d = req_i.divisor;
      cnt_d = 6'd43; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[17]) begin
        rem_d = trial[16:0];
        quo_d = {quo_q[41:0], 1'b1};
      end else begin
        rem_d = {rem_q[15:0], quo_q[42]};
        quo_d = {quo_q[41:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quotient = quo_q;
endmodule

@@ rtl/pixel_hit_occupancy_counter.sv @@
// top level of the pixel hit occupancy counter
// hit: two divides in turn, column then row, then a read and a write of the pixel sum if accepted
// end of event: sweeps every pixel, a read then a write per pixel
// read: one memory read of the trigger count; unused command: result holds only the events seen
// reset: clearing pass over every entry of both memories, no word accepted meanwhile
// a finished result waits in the output register; next word accepted once it is taken
module pixel_hit_occupancy_counter import phoc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  phoc_cfg_if.sink   cfg_i,
  phoc_in_if.sink    in_i,
  phoc_out_if.source out_o
);
  `include "pixel_hit_occupancy_counter_defines.svh"

  typedef enum logic [3:0] {
    StClear, StIdle, StDivC, StDivR, StHitRd, StHitWr,
    StEoeRd, StEoeWr, StRdWait, StOut
  } state_e;

  state_e      state_q;
  logic [15:0] pitch_q;
  logic [7:0]  cols_q, rows_q;
  logic [31:0] thr_q, events_q;
  in_word_t    item_q;
  out_word_t   res_q;
  logic [AddrW:0] addr_q;
  logic [42:0] col_q;
  logic        in_matrix;
  logic [SizeW-1:0] cols_eff, rows_eff;
  logic [26:0] w_mag, h_mag;
  logic signed [45:0] x2, y2, w, h;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic [AddrW-1:0] mem_addr;
  logic        sum_we, cnt_we;
  logic [31:0] sum_wdata, cnt_wdata, sum_rdata, cnt_rdata;
  logic        pix_used;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == StIdle);
  assign out_o.valid = (state_q == StOut);
  assign out_o.data  = res_q;

  // effective matrix size clamped to the store
  assign cols_eff = ({3'b0, cols_q} > SizeW'(MaxColumns)) ? SizeW'(MaxColumns) : {3'b0, cols_q};
  assign rows_eff = ({3'b0, rows_q} > SizeW'(MaxRows)) ? SizeW'(MaxRows) : {3'b0, rows_q};

  // half extents times two, one 11 x 16 multiply each
  assign x2    = 46'(item_q.hit_x) <<< 1;
  assign y2    = 46'(item_q.hit_y) <<< 1;
  assign w_mag = cols_eff * pitch_q;
  assign h_mag = rows_eff * pitch_q;
  assign w     = $signed({19'b0, w_mag});
  assign h     = $signed({19'b0, h_mag});
  assign in_matrix = (pitch_q != '0) && (x2 > -w) && (x2 < w) && (y2 > -h) && (y2 < h);

  assign div_req.start    = (state_q == StIdle && in_i.valid && in_i.data.command == CmdHit)
                          | (state_q == StDivC && div_rsp.done);
  assign div_req.divisor  = {pitch_q, 1'b0};
  assign div_req.dividend = (state_q == StDivC) ? 43'(h - y2)
                          : 43'((46'(in_i.data.hit_x) <<< 1) + w);

  phoc_divider u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // pixel in use during the end of event sweep: address is column major
  assign pix_used = ({4'b0, addr_q[AddrW-1:RowW]} < cols_eff)
                 && ({4'b0, addr_q[RowW-1:0]} < rows_eff);

  always_comb begin
    mem_addr  = addr_q[AddrW-1:0];
    sum_we    = 1'b0; cnt_we = 1'b0;
    sum_wdata = '0;   cnt_wdata = cnt_rdata;
    unique case (state_q)
      StClear: begin
        sum_we = 1'b1; cnt_we = 1'b1; cnt_wdata = '0;
      end
      // read pixel address goes to the memory on the accepting edge
      StIdle: begin
        mem_addr = {in_i.data.read_column, in_i.data.read_row};
      end
      StHitWr: begin
        sum_we = 1'b1; sum_wdata = sat_inc(sum_rdata, item_q.hit_energy);
      end
      StEoeWr: begin
        sum_we = 1'b1;
        if (pix_used && sum_rdata > thr_q) begin
          cnt_we = 1'b1; cnt_wdata = sat_inc(cnt_rdata, 32'd1);
        end
      end
      default: ;
    endcase
  end

  phoc_ram #(.Width(32), .Depth(Pixels)) u_sum (
    .clk_i, .we_i(sum_we), .addr_i(mem_addr), .wdata_i(sum_wdata), .rdata_o(sum_rdata));
  phoc_ram #(.Width(32), .Depth(Pixels)) u_cnt (
    .clk_i, .we_i(cnt_we), .addr_i(mem_addr), .wdata_i(cnt_wdata), .rdata_o(cnt_rdata));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClear;
      addr_q   <= '0;
      pitch_q  <= 16'd25;
      cols_q   <= 8'd128;
      rows_q   <= 8'd128;
      thr_q    <= '0;
      events_q <= '0;
      item_q   <= '0;
      res_q    <= '0;
      col_q    <= '0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.data.index)
          3'(RegPitch): pitch_q <= cfg_i.data.data[15:0];
          3'(RegCols):  cols_q  <= cfg_i.data.data[7:0];
          3'(RegRows):  rows_q  <= cfg_i.data.data[7:0];
          3'(RegThr):   thr_q   <= cfg_i.data.data;
          default: ;
        endcase
      end
      unique case (state_q)
        StClear: begin
          addr_q <= addr_q + 1'b1;
          if (addr_q[AddrW-1:0] == AddrW'(Pixels - 1)) begin
            state_q <= StIdle;
          end
        end
        StIdle: if (in_i.valid) begin
          item_q <= in_i.data;
          unique case (in_i.data.command)
            CmdHit: begin
              res_q   <= '0;
              state_q <= StDivC;
            end
            CmdEoe: begin
              res_q   <= '0;
              addr_q  <= '0;
              state_q <= StEoeRd;
            end
            CmdRead: begin
              res_q   <= '0;
              addr_q  <= {1'b0, in_i.data.read_column, in_i.data.read_row};
              state_q <= StRdWait;
            end
            default: begin
              res_q   <= '{events_seen: events_q, default: '0};
              state_q <= StOut;
            end
          endcase
        end
        StDivC: if (div_rsp.done) begin
          col_q   <= div_rsp.quotient;
          state_q <= StDivR;
        end
        StDivR: if (div_rsp.done) begin
          if (in_matrix && col_q < 43'(cols_eff) && div_rsp.quotient < 43'(rows_eff)) begin
            addr_q  <= {1'b0, col_q[ColW-1:0], div_rsp.quotient[RowW-1:0]};
            res_q   <= '{hit_accepted: 1'b1,
                         hit_column: 7'(col_q[ColW-1:0]),
                         hit_row: 7'(div_rsp.quotient[RowW-1:0]),
                         trigger_count: '0,
                         events_seen: events_q};
            state_q <= StHitRd;
          end else begin
            res_q   <= '{events_seen: events_q, default: '0};
            state_q <= StOut;
          end
        end
        StHitRd: state_q <= StHitWr;
        StHitWr: state_q <= StOut;
        StEoeRd: state_q <= StEoeWr;
        StEoeWr: begin
          addr_q <= addr_q + 1'b1;
          if (addr_q[AddrW-1:0] == AddrW'(Pixels - 1)) begin
            events_q <= sat_inc(events_q, 32'd1);
            res_q.events_seen <= sat_inc(events_q, 32'd1);
            state_q <= StOut;
          end else begin
            state_q <= StEoeRd;
          end
        end
        StRdWait: begin
          // pixels outside the matrix in use read as zero
          if ({4'b0, item_q.read_column} < cols_eff && {4'b0, item_q.read_row} < rows_eff) begin
            res_q <= '{trigger_count: cnt_rdata, events_seen: events_q, default: '0};
          end else begin
            res_q <= '{events_seen: events_q, default: '0};
          end
          state_q <= StOut;
        end
        StOut: if (out_o.ready) begin
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `PHOC_ASSERT_NEXT(a_out_hold, out_o.valid && !out_o.ready, out_o.valid, "result dropped")
  `PHOC_ASSERT_ALWAYS(a_no_accept_busy, !(in_i.ready && out_o.valid), "accept while busy")
  `PHOC_ASSERT_NEXT(a_hit_div, in_i.valid && in_i.ready && in_i.data.command == CmdHit,
                    state_q == StDivC, "hit did not start divider")
endmodule
